@@ hw/rtl/bspe_pkg.sv @@
// Package for the B-spline point evaluator: widths, defaults, sequencer states.
// Used by every module under hw/rtl; depends on nothing.
`timescale 1ns / 1ps
package bspe_pkg;
  localparam int unsigned MaxPointsDef = 64;
  localparam int unsigned MaxOrderDef  = 8;
  localparam int unsigned CoordW = 32;
  localparam int unsigned UW     = 22;
  localparam int unsigned CfgW   = 7;
  localparam int unsigned RegIdxW = 2;

  localparam logic [RegIdxW-1:0] RegOrder = 2'd0;
  localparam logic [RegIdxW-1:0] RegMode  = 2'd1;
  localparam logic [RegIdxW-1:0] RegCount = 2'd2;

  localparam logic ActLoad = 1'b0;

  typedef enum logic [3:0] {
    StIdle, StSpan, StFetch, StFetchWait, StBlendSet, StMul, StMulAdd, StDivGo, StDiv,
    StWrite, StDone, StErr
  } state_e;

  // Command to the divider: numerator magnitude and divisor.
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [15:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
  } div_rsp_t;
endpackage

@@ hw/rtl/bspe_div.sv @@
// Shared restoring divider, one quotient bit per cycle, truncating quotient.
// Depends on bspe_pkg.
`timescale 1ns / 1ps
module bspe_div import bspe_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);
  logic [63:0] quo_q, quo_d;
  logic [16:0] rem_q, rem_d;
  logic [15:0] den_q, den_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [17:0] trial;

  // One restoring step per cycle over the 64 numerator bits.
  always_comb begin
    quo_d = quo_q; rem_d = rem_q; den_d = den_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    trial = '0;
    if (req_i.start) begin
      quo_d = req_i.num;
      rem_d = '0; den_d = req_i.den; cnt_d = 7'd64; busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q, quo_q[63]} - {2'b00, den_q};
      if (!trial[17]) rem_d = trial[16:0];
      else rem_d = {rem_q[15:0], quo_q[63]};
      quo_d = {quo_q[62:0], ~trial[17]};
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d; den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
endmodule

@@ hw/rtl/bspline_point_eval.sv @@
// Top level of the B-spline point evaluator: control point store, de Boor
// sequencer, shared multiplier and the divider. Depends on bspe_pkg, bspe_div.
`timescale 1ns / 1ps
// Usage: raise start with the item fields while busy is low. A load item
// (action 0) writes one control point when accepted and gives no result. An
// evaluate item (action 1) gives one result: point_x/y/z and domain_error,
// shown for exactly one cycle with done_o high. The receiver cannot stall.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) land at once and
// must come only while busy is low. Reset sets order 4, uniform knots and
// four points; the store holds nothing defined until loaded.
// An evaluate runs in order: a span search that steps once per skipped span
// (at most n-k), a fetch of the k points through the registered store read,
// and the k(k-1)/2 blends. Per coordinate a blend has a setup, two multiply
// steps, a divider launch, the divider run and a write back; a blend over an
// empty knot interval has only a setup and a write back. A done state ends
// the run and the strobe is registered from it. The 64-step serial divider
// dominates the run. An error result is strobed from the error state that
// follows the span check. busy is low in the strobe cycle.
module bspline_point_eval import bspe_pkg::*; #(
  parameter int unsigned MaxPoints = MaxPointsDef,
  parameter int unsigned MaxOrder  = MaxOrderDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic                      cfg_we_i,
  input  logic [RegIdxW-1:0]        cfg_idx_i,
  input  logic [CfgW-1:0]           cfg_data_i,
  input  logic                      action_i,
  input  logic [5:0]                point_index_i,
  input  logic signed [CoordW-1:0]  coord_x_i,
  input  logic signed [CoordW-1:0]  coord_y_i,
  input  logic signed [CoordW-1:0]  coord_z_i,
  input  logic [UW-1:0]             param_u_i,
  output logic                      done_o,
  output logic signed [CoordW-1:0]  point_x_o,
  output logic signed [CoordW-1:0]  point_y_o,
  output logic signed [CoordW-1:0]  point_z_o,
  output logic                      domain_error_o
);
  localparam int unsigned PW = $clog2(MaxPoints);
  localparam int unsigned OW = $clog2(MaxOrder);
  localparam int unsigned NW = $clog2(MaxPoints + 1);
  localparam int unsigned KW = $clog2(MaxOrder + 1);
  localparam int unsigned TW = NW + 1;

  // Configuration registers.
  logic [3:0] order_q;
  logic       mode_q;
  logic [6:0] count_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= 4'd4; mode_q <= 1'b0; count_q <= 7'd4;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegOrder: order_q <= cfg_data_i[3:0];
        RegMode:  mode_q  <= cfg_data_i[0];
        RegCount: count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Control point store and working row.
  logic [3*CoordW-1:0] mem_q [MaxPoints];
  logic [3*CoordW-1:0] rd_q;
  logic [PW-1:0]       rd_addr;
  logic signed [CoordW-1:0] work_q [MaxOrder][3];

  state_e state_q, state_d;
  logic [TW-1:0] span_q;          // candidate span index i
  logic [TW-1:0] off_q;           // o = i - k
  logic [KW-1:0] r_q, j_q;
  logic [1:0]    c_q;
  logic [UW-1:0] u_q;
  logic [TW+16:0] wa_q, wb_q;
  logic [15:0]   dd_q;
  logic signed [63:0] acc_q;
  logic [63:0]   mag;
  div_req_t dreq;
  div_rsp_t drsp;

  wire load_go = start && !busy && action_i == ActLoad;
  wire eval_go = start && !busy && action_i != ActLoad;

  always_ff @(posedge clk_i) begin
    if (load_go && (MaxPoints >= 64 || {1'b0, point_index_i} < 7'(MaxPoints)))
      mem_q[PW'(point_index_i)] <= {coord_z_i, coord_y_i, coord_x_i};
    rd_q <= mem_q[rd_addr];
  end

  // Knot generator: k, n from configuration, i in whole numbers.
  function automatic logic [TW-1:0] knot(input logic [TW-1:0] i, input logic md,
      input logic [TW-1:0] k, input logic [TW-1:0] n);
    if (!md) return i;
    if (i < k) return '0;
    if (i < n) return i - k + 1'b1;
    return n - k + 1'b1;
  endfunction

  wire [TW-1:0] kk = TW'(order_q);
  wire [TW-1:0] nn = TW'(count_q);
  wire cfg_bad = order_q < 4'd2 || 32'(order_q) > MaxOrder || count_q < 7'(order_q)
                 || 32'(count_q) > MaxPoints;
  wire [TW+16:0] lo_b = mode_q ? '0 : {1'b0, TW'(kk - 1'b1), 16'd0};
  wire [TW+16:0] hi_b = mode_q ? {1'b0, TW'(nn - kk + 1'b1), 16'd0} : {1'b0, nn, 16'd0};
  wire [TW+16:0] u_ext = (TW+17)'(u_q);
  wire [TW-1:0] th = knot(off_q + kk + TW'(j_q), mode_q, kk, nn);
  wire [TW-1:0] tl = knot(off_q + TW'(r_q) + TW'(j_q), mode_q, kk, nn);
  wire [TW-1:0] last_j = kk - TW'(r_q) - 1'b1;
  wire [TW+16:0] span_knot = {1'b0, knot(span_q, mode_q, kk, nn), 16'd0};
  assign rd_addr = PW'(off_q + TW'(j_q));

  // Shared signed multiplier: one product per cycle into the accumulator in StMul and StMulAdd.
  logic signed [CoordW-1:0] mul_a;
  logic signed [TW+17:0]    mul_b;
  logic signed [CoordW+TW+17:0] prod;
  always_comb begin
    if (state_q == StMul) begin
      mul_a = work_q[j_q[OW-1:0]][c_q];
      mul_b = $signed({1'b0, wa_q});
    end else begin
      mul_a = work_q[OW'(j_q + 1'b1)][c_q];
      mul_b = $signed({1'b0, wb_q});
    end
    prod = mul_a * mul_b;
    mag = acc_q[63] ? 64'(-acc_q) : 64'(acc_q);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:      if (eval_go) state_d = StSpan;
      StSpan: begin
        if (cfg_bad || u_ext < lo_b || u_ext > hi_b) state_d = StErr;
        else if (!(span_q < nn && span_knot < u_ext))
          state_d = StFetch;
      end
      StFetch:     state_d = StFetchWait;
      StFetchWait: state_d = (TW'(j_q) == kk - 1'b1) ? StBlendSet : StFetch;
      StBlendSet:  state_d = (th > tl) ? StMul : StWrite;
      StMul:       state_d = StMulAdd;
      StMulAdd:    state_d = StDivGo;
      StDivGo:     state_d = StDiv;
      StDiv:       if (drsp.done) state_d = StWrite;
      StWrite: begin
        if (c_q == 2'd2 || th <= tl) begin
          if (TW'(j_q) == last_j && TW'(r_q) == kk - 1'b1) state_d = StDone;
          else state_d = StBlendSet;
        end else state_d = StBlendSet;
      end
      StDone:      state_d = StIdle;
      StErr:       state_d = StIdle;
      default:     state_d = StIdle;
    endcase
  end

  // Outputs of the sequencer; the divisor is the knot interval in whole
  // units, so the numerator is rounded and scaled down by 2^16 first.
  always_comb begin
    busy = state_q != StIdle;
    dreq.start = state_q == StDivGo;
    dreq.num   = (mag + {33'd0, dd_q, 15'd0}) >> 16;
    dreq.den   = dd_q;
  end

  bspe_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; done_o <= 1'b0;
    end else begin
      state_q <= state_d;
      done_o  <= state_q == StDone || state_q == StErr;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: begin
        u_q <= param_u_i; span_q <= kk; j_q <= '0;
      end
      StSpan: begin
        if (span_q < nn && span_knot < u_ext)
          span_q <= span_q + 1'b1;
        off_q <= span_q - kk;
        j_q <= '0;
      end
      StFetch: ;
      StFetchWait: begin
        work_q[j_q[OW-1:0]][0] <= rd_q[CoordW-1:0];
        work_q[j_q[OW-1:0]][1] <= rd_q[2*CoordW-1:CoordW];
        work_q[j_q[OW-1:0]][2] <= rd_q[3*CoordW-1:2*CoordW];
        if (TW'(j_q) == kk - 1'b1) begin
          j_q <= '0; r_q <= KW'(1); c_q <= '0;
        end else j_q <= j_q + 1'b1;
      end
      StBlendSet: begin
        wa_q <= {1'b0, th, 16'd0} - u_ext;
        wb_q <= u_ext - {1'b0, tl, 16'd0};
        dd_q <= 16'(th - tl);
      end
      // The multiplier runs twice per coordinate: first term, then the sum.
      StMul:    acc_q <= 64'(prod);
      StMulAdd: acc_q <= acc_q + 64'(prod);
      StDiv: begin
        if (drsp.done) begin
          acc_q <= acc_q[63] ? -$signed(drsp.quo) : $signed(drsp.quo);
        end
      end
      StWrite: begin
        if (th > tl) work_q[j_q[OW-1:0]][c_q] <= acc_q[CoordW-1:0];
        if (c_q == 2'd2 || th <= tl) begin
          c_q <= '0;
          if (TW'(j_q) == last_j) begin
            j_q <= '0; r_q <= r_q + 1'b1;
          end else j_q <= j_q + 1'b1;
        end else c_q <= c_q + 1'b1;
      end
      StDone: begin
        point_x_o <= work_q[0][0]; point_y_o <= work_q[0][1];
        point_z_o <= work_q[0][2]; domain_error_o <= 1'b0;
      end
      StErr: begin
        point_x_o <= '0; point_y_o <= '0; point_z_o <= '0; domain_error_o <= 1'b1;
      end
      default: ;
    endcase
  end
endmodule

@@ verif/bspline_point_eval_tb.sv @@
// Self-checking testbench for bspline_point_eval: directed table, then fixed and random phases.
// Depends on bspe_pkg and the bspline_point_eval RTL; reads no files.
`timescale 1ns / 1ps
module bspline_point_eval_tb;
  import bspe_pkg::*;

  localparam logic ActEval = ~ActLoad;
  localparam logic [RegIdxW-1:0] RegSpare = 2'd3;
  localparam int unsigned CycleLimit = 30000000;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    logic                     err;
  } curve_pt_t;

  typedef struct {
    logic        act;
    logic [5:0]  slot;
    logic [31:0] x, y, z;
    logic [21:0] u;
    logic        typed;
    curve_pt_t   want;
  } row_t;

  logic clk_i, rst_ni, start, busy, cfg_we_i, done_o;
  logic [RegIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0] cfg_data_i;
  logic action_i;
  logic [5:0] point_index_i;
  logic signed [CoordW-1:0] coord_x_i, coord_y_i, coord_z_i;
  logic [UW-1:0] param_u_i;
  logic signed [CoordW-1:0] point_x_o, point_y_o, point_z_o;
  logic domain_error_o;

  bspline_point_eval uut (.*);

  // Mirror of the block's state and configuration.
  longint     cp [64][3];
  bit         written [64];
  int unsigned ord_q = 4, mode_q = 0, cnt_q = 4;
  curve_pt_t  expected_points [$];
  int unsigned err_count, loads, evals, faults, phases, items;
  longint unsigned cycles;

  // Clock and watchdog.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("bspline_point_eval regression: fail");
      $finish;
    end
  end

  function automatic longint knot(longint i, longint k, longint n);
    if (mode_q == 0) return i;
    if (i < k) return 0;
    if (i < n) return i - k + 1;
    return n - k + 1;
  endfunction

  function automatic longint round_div(longint num, longint den);
    if (num >= 0) return (num + den / 2) / den;
    return -((-num + den / 2) / den);
  endfunction

  // de Boor evaluation at u with the current configuration.
  function automatic curve_pt_t eval_curve(logic [21:0] u);
    longint k, n, lo, hi, s, o, th, tl, d, uu;
    longint row [8][3];
    curve_pt_t res;
    k = ord_q;
    n = cnt_q;
    uu = u;
    res = '0;
    if (k < 2 || k > 8 || n < k || n > 64) begin
      res.err = 1'b1;
      return res;
    end
    lo = (mode_q == 0) ? (k - 1) << 16 : 0;
    hi = (mode_q == 0) ? n << 16 : (n - k + 1) << 16;
    if (uu < lo || uu > hi) begin
      res.err = 1'b1;
      return res;
    end
    s = k;
    while (s < n && (knot(s, k, n) << 16) < uu) s++;
    o = s - k;
    for (int j = 0; j < k; j++)
      for (int c = 0; c < 3; c++) row[j][c] = cp[(o + j) % 64][c];
    for (int r = 1; r < k; r++)
      for (int j = 0; j + r < k; j++) begin
        th = knot(o + k + j, k, n) << 16;
        tl = knot(o + r + j, k, n) << 16;
        d = th - tl;
        if (d > 0)
          for (int c = 0; c < 3; c++)
            row[j][c] = round_div(row[j][c] * (th - uu) + row[j + 1][c] * (uu - tl), d);
      end
    res.x = row[0][0][31:0];
    res.y = row[0][1][31:0];
    res.z = row[0][2][31:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, longint want, longint got);
    $display("mismatch %s: expected %0h, got %0h (cycle %0d)", what, want, got, cycles);
    err_count++;
  endtask

  // Result checker: every strobe must match the oldest expectation.
  always @(posedge clk_i) begin
    curve_pt_t w;
    if (rst_ni && done_o) begin
      if (expected_points.size() == 0) begin
        report_mismatch("unexpected result", 0, 1);
      end else begin
        w = expected_points.pop_front();
        if (point_x_o !== w.x) report_mismatch("point_x", w.x, point_x_o);
        if (point_y_o !== w.y) report_mismatch("point_y", w.y, point_y_o);
        if (point_z_o !== w.z) report_mismatch("point_z", w.z, point_z_o);
        if (domain_error_o !== w.err) report_mismatch("domain_error", w.err, domain_error_o);
      end
    end
  end

  // Drives one item at a falling edge and holds it until accepted.
  task automatic send_item(logic act, logic [5:0] slot, logic [31:0] x, logic [31:0] y,
                           logic [31:0] z, logic [21:0] u, bit typed, curve_pt_t want);
    start = 1'b1;
    action_i = act;
    point_index_i = slot;
    coord_x_i = x;
    coord_y_i = y;
    coord_z_i = z;
    param_u_i = u;
    do @(posedge clk_i); while (busy);
    items++;
    if (act == ActLoad) begin
      cp[slot][0] = longint'(signed'(x));
      cp[slot][1] = longint'(signed'(y));
      cp[slot][2] = longint'(signed'(z));
      written[slot] = 1'b1;
      loads++;
    end else begin
      if (!typed) want = eval_curve(u);
      expected_points = {expected_points, want};
      evals++;
      if (want.err) faults++;
    end
    @(negedge clk_i);
  endtask

  // Lets the block drain completely; loads give no result, so wait a little more.
  task automatic drain;
    start = 1'b0;
    while (expected_points.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    while (busy) @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [RegIdxW-1:0] idx, logic [CfgW-1:0] data);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    case (idx)
      RegOrder: ord_q = data & 7'hF;
      RegMode:  mode_q = data & 7'h1;
      RegCount: cnt_q = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Sender pacing: bursts of random length, random gaps between them.
  int burst_left;
  task automatic pace;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 2) != 0) begin
        start = 1'b0;
        repeat ($urandom_range(1, 20)) @(negedge clk_i);
      end
    end
  endtask

  task automatic run_phase(int unsigned k, int unsigned md, int unsigned n, int unsigned nev);
    longint lo, hi;
    logic [21:0] u;
    curve_pt_t none;
    none = '0;
    drain();
    cfg_write(RegCount, n[6:0]);
    cfg_write(RegOrder, {3'($urandom_range(0, 7)), k[3:0]});
    cfg_write(RegMode, {6'($urandom_range(0, 63)), md[0]});
    phases++;
    // Fill every slot the curve can read before evaluating.
    if (n <= 64)
      for (int s = 0; s < n; s++)
        if (!written[s]) begin
          send_item(ActLoad, s, $urandom, $urandom, $urandom, $urandom, 0, none);
          pace();
        end
    lo = (md == 0) ? longint'(k - 1) << 16 : 0;
    hi = (md == 0) ? longint'(n) << 16 : (longint'(n) - k + 1) << 16;
    for (int e = 0; e < nev; ) begin
      case ($urandom_range(0, 9))
        0: send_item(ActLoad, $urandom_range(0, 63), $urandom, $urandom, $urandom,
                     $urandom, 0, none);
        1: begin
          send_item(ActEval, $urandom, $urandom, $urandom, $urandom,
                    $urandom_range(0, 22'h3FFFFF), 0, none);
          e++;
        end
        default: begin
          if (hi < lo) u = $urandom;
          else case ($urandom_range(0, 5))
            0: u = lo;
            1: u = hi;
            2: u = lo + (longint'($urandom_range(0, (hi - lo) >> 16)) << 16);
            default: u = lo + $urandom_range(0, hi - lo);
          endcase
          send_item(ActEval, $urandom, $urandom, $urandom, $urandom, u, 0, none);
          e++;
        end
      endcase
      pace();
    end
  endtask

  row_t dir_tab [$];

  function automatic curve_pt_t fault_pt;
    curve_pt_t p;
    p = '0;
    p.err = 1'b1;
    return p;
  endfunction

  initial begin
    int unsigned k, n;
    curve_pt_t none;
    none = '0;
    rst_ni = 1'b0;
    start = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = RegOrder;
    cfg_data_i = '0;
    action_i = ActLoad;
    point_index_i = '0;
    coord_x_i = '0;
    coord_y_i = '0;
    coord_z_i = '0;
    param_u_i = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed table at reset settings: order 4, uniform knots, four points.
    dir_tab = '{
      '{ActLoad, 6'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 22'h0, 0, none},
      '{ActLoad, 6'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 22'h3FFFFF, 0, none},
      '{ActLoad, 6'd2, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 22'h0, 0, none},
      '{ActLoad, 6'd3, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 22'h0, 0, none},
      '{ActLoad, 6'd63, 32'h1234_5678, 32'h9ABC_DEF0, 32'h5555_AAAA, 22'h0, 0, none},
      '{ActEval, 6'd0, 32'h0, 32'h0, 32'h0, 22'h30000, 0, none},
      '{ActEval, 6'd0, 32'h0, 32'h0, 32'h0, 22'h38000, 0, none},
      '{ActEval, 6'd0, 32'h0, 32'h0, 32'h0, 22'h40000, 0, none},
      '{ActEval, 6'd0, 32'h0, 32'h0, 32'h0, 22'h0, 1, fault_pt()},
      '{ActEval, 6'd0, 32'h0, 32'h0, 32'h0, 22'h2FFFF, 1, fault_pt()},
      '{ActEval, 6'd0, 32'h0, 32'h0, 32'h0, 22'h40001, 1, fault_pt()},
      '{ActEval, 6'h3F, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 22'h3FFFFF, 1,
        fault_pt()},
      '{ActEval, 6'd0, 32'h0, 32'h0, 32'h0, 22'h31234, 0, none}
    };
    foreach (dir_tab[i])
      send_item(dir_tab[i].act, dir_tab[i].slot, dir_tab[i].x, dir_tab[i].y, dir_tab[i].z,
                dir_tab[i].u, dir_tab[i].typed, dir_tab[i].want);

    // The spare register index must be ignored.
    drain();
    cfg_write(RegSpare, 7'h7F);

    // Extreme and special settings, including invalid ones.
    run_phase(2, 0, 2, 20);
    run_phase(2, 1, 64, 20);
    run_phase(8, 0, 8, 4);
    run_phase(8, 1, 64, 4);
    run_phase(8, 1, 8, 4);
    run_phase(3, 1, 5, 20);
    run_phase(0, 0, 4, 4);
    run_phase(1, 1, 4, 4);
    run_phase(9, 0, 20, 4);
    run_phase(15, 1, 20, 4);
    run_phase(4, 0, 3, 4);
    run_phase(4, 1, 65, 4);
    run_phase(2, 0, 127, 4);
    run_phase(2, 1, 0, 4);

    // Random phases, mostly low orders so that the run stays short.
    while (items < 1200) begin
      if ($urandom_range(0, 9) == 0) begin
        run_phase($urandom_range(5, 8), $urandom_range(0, 1), $urandom_range(8, 64), 3);
      end else if ($urandom_range(0, 9) == 0) begin
        run_phase($urandom_range(0, 15), $urandom_range(0, 1), $urandom_range(0, 127), 5);
      end else begin
        k = $urandom_range(2, 4);
        n = k + $urandom_range(0, 12);
        run_phase(k, $urandom_range(0, 1), n, 40);
      end
    end

    drain();
    repeat (20) @(negedge clk_i);
    $display("covered %0d items in %0d settings: %0d loads, %0d evaluations (%0d errors)",
             items, phases, loads, evals, faults);
    if (err_count == 0) begin
      $display("bspline_point_eval regression: pass");
    end else begin
      $display("%0d mismatches", err_count);
      $display("bspline_point_eval regression: fail");
    end
    $finish;
  end
endmodule

@@ sim.f @@
hw/rtl/bspe_pkg.sv
hw/rtl/bspe_div.sv
hw/rtl/bspline_point_eval.sv
verif/bspline_point_eval_tb.sv
